// ===== sv/mcorr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcorr_pkg
// Shared widths, constants and types of the magnetometer correction block.
// ----------------------------------------------------------------------------
package mcorr_pkg;

  localparam int MEAS_W    = 24;
  localparam int COEFF_W   = 18;
  localparam int NUM_AXES  = 3;
  localparam int ROW_W     = NUM_AXES * COEFF_W;
  localparam int PROD_W    = COEFF_W + MEAS_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int SQ_W      = 2 * MEAS_W - 1;
  localparam int SUMSQ_W   = 2 * MEAS_W;
  localparam int ROOT_W    = MEAS_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int CFG_IDX_W = 8;

  localparam logic signed [MEAS_W-1:0] CORR_MAX = 24'sh7FFFFF;
  localparam logic signed [MEAS_W-1:0] CORR_MIN = 24'sh800000;
  localparam logic [MEAS_W-1:0]        MAG_MAX  = 24'd14529495;

  // Reset rows give the identity matrix.
  localparam logic [ROW_W-1:0] ROW0_RESET = 54'd16384;
  localparam logic [ROW_W-1:0] ROW1_RESET = 54'd4294967296;
  localparam logic [ROW_W-1:0] ROW2_RESET = 54'd1125899906842624;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0 = 8'd0,
    CFG_ROW1 = 8'd1,
    CFG_ROW2 = 8'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [MEAS_W-1:0] x;
    logic signed [MEAS_W-1:0] y;
    logic signed [MEAS_W-1:0] z;
    logic                     sat;
  } corr_vec_t;

endpackage

// ===== sv/mcorr_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcorr_lane
// One matrix row: three products, sum, floor shift, saturation and square.
// ----------------------------------------------------------------------------
module mcorr_lane #(
  parameter int COEFF_FRAC_BITS = 14
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [mcorr_pkg::ROW_W-1:0]         row,
  input  logic signed [mcorr_pkg::MEAS_W-1:0] meas_x,
  input  logic signed [mcorr_pkg::MEAS_W-1:0] meas_y,
  input  logic signed [mcorr_pkg::MEAS_W-1:0] meas_z,
  output logic signed [mcorr_pkg::MEAS_W-1:0] corr,
  output logic                                sat,
  output logic [mcorr_pkg::SQ_W-1:0]          sq
);
  import mcorr_pkg::*;

  logic signed [COEFF_W-1:0]  coef [NUM_AXES];
  logic signed [MEAS_W-1:0]   meas [NUM_AXES];
  logic signed [PROD_W-1:0]   prod [NUM_AXES];
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    shifted;
  logic                       over_hi;
  logic                       over_lo;
  logic signed [MEAS_W-1:0]   corr_s3;
  logic                       sat_s3;
  logic signed [SUMSQ_W-1:0]  sq_full;

  assign meas[0] = meas_x;
  assign meas[1] = meas_y;
  assign meas[2] = meas_z;

  for (genvar c = 0; c < NUM_AXES; c++) begin : g_col
    assign coef[c] = row[c*COEFF_W +: COEFF_W];
    always_ff @(posedge clk) begin
      if (en) begin
        prod[c] <= coef[c] * meas[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]);
    end
  end

  // Arithmetic shift floors toward minus infinity.
  assign shifted = sum >>> COEFF_FRAC_BITS;
  assign over_hi = shifted > SUM_W'(CORR_MAX);
  assign over_lo = shifted < SUM_W'(CORR_MIN);

  always_ff @(posedge clk) begin
    if (en) begin
      if (over_hi) begin
        corr_s3 <= CORR_MAX;
      end else if (over_lo) begin
        corr_s3 <= CORR_MIN;
      end else begin
        corr_s3 <= shifted[MEAS_W-1:0];
      end
      sat_s3 <= over_hi | over_lo;
    end
  end

  assign sq_full = corr_s3 * corr_s3;

  always_ff @(posedge clk) begin
    if (en) begin
      sq   <= sq_full[SQ_W-1:0];
      corr <= corr_s3;
      sat  <= sat_s3;
    end
  end

endmodule

// ===== sv/mcorr_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcorr_isqrt
// Pipelined integer square root, one result bit per stage, with side data.
// ----------------------------------------------------------------------------
module mcorr_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [mcorr_pkg::SUMSQ_W-1:0] rad,
  input  mcorr_pkg::corr_vec_t          side_in,
  output logic [mcorr_pkg::ROOT_W-1:0]  root,
  output mcorr_pkg::corr_vec_t          side_out
);
  import mcorr_pkg::*;

  logic [REM_W-1:0]   rem_q  [ROOT_W-1];
  logic [SUMSQ_W-1:0] rad_q  [ROOT_W-1];
  logic [ROOT_W-1:0]  root_q [ROOT_W];
  corr_vec_t          side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [REM_W-1:0]   rem_in;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    logic [ROOT_W-1:0]  root_in;
    logic [SUMSQ_W-1:0] rad_in;
    corr_vec_t          stg_side;
    logic               ge;

    if (k == 0) begin : g_first
      assign rem_in   = '0;
      assign root_in  = '0;
      assign rad_in   = rad;
      assign stg_side = side_in;
    end else begin : g_next
      assign rem_in   = rem_q[k-1];
      assign root_in  = root_q[k-1];
      assign rad_in   = rad_q[k-1];
      assign stg_side = side_q[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[SUMSQ_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
        side_q[k] <= stg_side;
      end
    end

    if (k < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= ge ? (rem_sh - trial) : rem_sh;
          rad_q[k] <= rad_in << 2;
        end
      end
    end
  end

  assign root     = root_q[ROOT_W-1];
  assign side_out = side_q[ROOT_W-1];

endmodule

// ===== sv/magnetometer_matrix_correct.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_matrix_correct
// 3x3 fixed-point correction of a magnetometer sample, with magnitude.
// ----------------------------------------------------------------------------
// Usage:
// A request on the input channel (in_valid/in_ready) carries one signed
// 24-bit sample meas_x/meas_y/meas_z. Each request produces exactly one
// request on the output channel (out_valid/out_ready) with the corrected,
// saturated components, the saturated flag and the floor of their magnitude.
// The pipeline has 29 stages. While the output side does not stall, it takes
// one new sample every cycle; the rate is set by the one-bit-per-stage square
// root pipeline, which keeps every stage busy with a different sample.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops; it rises again the cycle the result is taken.
// The three row registers are written through cfg_we/cfg_index/cfg_data and
// should be changed only while no sample is in flight. Synchronous reset
// empties the pipeline and loads the identity matrix.
// ----------------------------------------------------------------------------
module magnetometer_matrix_correct #(
  parameter int COEFF_FRAC_BITS = 14
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [mcorr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mcorr_pkg::ROW_W-1:0]            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [mcorr_pkg::MEAS_W-1:0]    meas_x,
  input  logic signed [mcorr_pkg::MEAS_W-1:0]    meas_y,
  input  logic signed [mcorr_pkg::MEAS_W-1:0]    meas_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [mcorr_pkg::MEAS_W-1:0]    corr_x,
  output logic signed [mcorr_pkg::MEAS_W-1:0]    corr_y,
  output logic signed [mcorr_pkg::MEAS_W-1:0]    corr_z,
  output logic [mcorr_pkg::MEAS_W-1:0]           magnitude,
  output logic                                   saturated
);
  import mcorr_pkg::*;

  // Four lane stages, one merge stage, one square-root stage per root bit.
  localparam int LANE_STAGES = 4;
  localparam int LATENCY     = LANE_STAGES + 1 + ROOT_W;

  logic [ROW_W-1:0]         rows [NUM_AXES];
  logic [LATENCY-1:0]       vld;
  logic                     adv;
  logic signed [MEAS_W-1:0] lane_corr [NUM_AXES];
  logic                     lane_sat  [NUM_AXES];
  logic [SQ_W-1:0]          lane_sq   [NUM_AXES];
  logic [SUMSQ_W-1:0]       sumsq;
  corr_vec_t                merged;
  corr_vec_t                result;
  logic [ROOT_W-1:0]        root;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= ROW0_RESET;
      rows[1] <= ROW1_RESET;
      rows[2] <= ROW2_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW0: rows[0] <= cfg_data;
        CFG_ROW1: rows[1] <= cfg_data;
        CFG_ROW2: rows[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together whenever the output register is free
  // or being emptied this cycle, so a bubble never blocks a new request.
  assign out_valid = vld[LATENCY-1];
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LATENCY-2:0], in_valid};
    end
  end

  // One lane per matrix row, all seeing the same sample.
  for (genvar r = 0; r < NUM_AXES; r++) begin : g_lane
    mcorr_lane #(
      .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (adv),
      .row   (rows[r]),
      .meas_x(meas_x),
      .meas_y(meas_y),
      .meas_z(meas_z),
      .corr  (lane_corr[r]),
      .sat   (lane_sat[r]),
      .sq    (lane_sq[r])
    );
  end

  // Merge stage: add the squares and gather the components and flags.
  always_ff @(posedge clk) begin
    if (adv) begin
      sumsq <= SUMSQ_W'(lane_sq[0]) + SUMSQ_W'(lane_sq[1]) + SUMSQ_W'(lane_sq[2]);
      merged.x   <= lane_corr[0];
      merged.y   <= lane_corr[1];
      merged.z   <= lane_corr[2];
      merged.sat <= lane_sat[0] | lane_sat[1] | lane_sat[2];
    end
  end

  // The components ride alongside the square root so they leave together.
  mcorr_isqrt u_isqrt (
    .clk     (clk),
    .en      (adv),
    .rad     (sumsq),
    .side_in (merged),
    .root    (root),
    .side_out(result)
  );

  assign corr_x    = result.x;
  assign corr_y    = result.y;
  assign corr_z    = result.z;
  assign saturated = result.sat;
  assign magnitude = root;

`ifndef SYNTHESIS
  // The pipeline is empty right after reset.
  a_empty_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A clipped result must hold at least one component at a rail.
  a_sat_at_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (corr_x == CORR_MAX || corr_x == CORR_MIN ||
       corr_y == CORR_MAX || corr_y == CORR_MIN ||
       corr_z == CORR_MAX || corr_z == CORR_MIN))
    else $error("saturated flag without a clipped component");

  // The magnitude of saturated components cannot exceed its bound.
  a_mag_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> magnitude <= MAG_MAX)
    else $error("magnitude out of range");
`endif

endmodule

// ===== test/magnetometer_matrix_correct_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_matrix_correct testbench
// Streams field samples through the 3x3 correction block under a series of
// matrix settings. A behavioral copy of the fixed-point math predicts every
// corrected vector, its magnitude and the clip flag, and the output stream is
// compared with those predictions while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import mcorr_pkg::*;

  localparam int COEFF_FRAC_BITS = 14;
  localparam int LIMIT_CYCLES    = 400000;
  localparam int HOLD_CYCLES     = 200;   // long receiver hold-off, fills the pipe
  localparam int TAIL_CYCLES     = 40;    // pipeline is 29 deep
  localparam int RANDOM_PHASES   = 10;
  localparam int PHASE_ITEMS     = 150;

  // Coefficient landmarks in signed Q4.14.
  localparam logic [COEFF_W-1:0] COEFF_MAX     = 18'h1FFFF;
  localparam logic [COEFF_W-1:0] COEFF_MIN     = 18'h20000;
  localparam logic [COEFF_W-1:0] COEFF_ONE     = 18'h04000;
  localparam logic [COEFF_W-1:0] COEFF_NEG_LSB = 18'h3FFFF;
  localparam logic [COEFF_W-1:0] COEFF_ZERO    = 18'h00000;

  localparam logic signed [MEAS_W-1:0] MEAS_MAX = CORR_MAX;
  localparam logic signed [MEAS_W-1:0] MEAS_MIN = CORR_MIN;

  typedef enum int {
    ROW_FULL,
    ROW_MODERATE,
    ROW_EXTREME,
    ROW_NEAR_IDENT
  } row_kind_t;

  typedef struct packed {
    logic signed [MEAS_W-1:0] x;
    logic signed [MEAS_W-1:0] y;
    logic signed [MEAS_W-1:0] z;
  } sample_t;

  typedef struct packed {
    logic signed [MEAS_W-1:0] x;
    logic signed [MEAS_W-1:0] y;
    logic signed [MEAS_W-1:0] z;
    logic [ROOT_W-1:0]        mag;
    logic                     sat;
  } corr_result_t;

  // All block inputs start at known values.
  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [ROW_W-1:0]            cfg_data  = '0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  logic signed [MEAS_W-1:0]    meas_x    = '0;
  logic signed [MEAS_W-1:0]    meas_y    = '0;
  logic signed [MEAS_W-1:0]    meas_z    = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [MEAS_W-1:0]    corr_x;
  logic signed [MEAS_W-1:0]    corr_y;
  logic signed [MEAS_W-1:0]    corr_z;
  logic [MEAS_W-1:0]           magnitude;
  logic                        saturated;

  // Testbench copy of the three row registers; it tracks every write.
  logic [ROW_W-1:0] row_cfg [NUM_AXES];

  sample_t      sample_q[$];             // samples waiting to be offered
  corr_result_t pending_corrections[$];  // predictions waiting for their result

  int n_queued   = 0;  // samples handed to the driver
  int n_accepted = 0;  // input requests taken by the block
  int n_results  = 0;
  int n_clipped  = 0;
  int n_settings = 0;
  int n_fail     = 0;
  int cycle_count = 0;

  // Idle controls, changed by the sequencer only while the block is empty.
  int gap_pct   = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;

  magnetometer_matrix_correct #(
    .COEFF_FRAC_BITS(COEFF_FRAC_BITS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .meas_x    (meas_x),
    .meas_y    (meas_y),
    .meas_z    (meas_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .corr_x    (corr_x),
    .corr_y    (corr_y),
    .corr_z    (corr_z),
    .magnitude (magnitude),
    .saturated (saturated)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Corrects one sample with the current matrix. Each row is an exact dot
  // product, floored by the fraction shift, then clipped to 24 bits. The
  // magnitude is built one root bit at a time from the clipped components.
  function automatic corr_result_t correct_sample(sample_t s);
    longint              axis [NUM_AXES];
    longint              comp [NUM_AXES];
    longint              coef;
    longint              acc;
    longint unsigned     energy;
    longint unsigned     root;
    longint unsigned     trial;
    logic signed [COEFF_W-1:0] k;
    corr_result_t        r;
    int                  row;
    int                  col;
    int                  b;
    axis[0] = s.x;
    axis[1] = s.y;
    axis[2] = s.z;
    r.sat = 1'b0;
    energy = 0;
    for (row = 0; row < NUM_AXES; row++) begin
      acc = 0;
      for (col = 0; col < NUM_AXES; col++) begin
        k = row_cfg[row][col*COEFF_W +: COEFF_W];
        coef = k;
        acc += coef * axis[col];
      end
      // Arithmetic shift of a signed value rounds toward minus infinity.
      acc = acc >>> COEFF_FRAC_BITS;
      if (acc > CORR_MAX) begin
        acc = CORR_MAX;
        r.sat = 1'b1;
      end else if (acc < CORR_MIN) begin
        acc = CORR_MIN;
        r.sat = 1'b1;
      end
      comp[row] = acc;
      energy += acc * acc;
    end
    root = 0;
    for (b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= energy) begin
        root = trial;
      end
    end
    r.x   = comp[0][MEAS_W-1:0];
    r.y   = comp[1][MEAS_W-1:0];
    r.z   = comp[2][MEAS_W-1:0];
    r.mag = root[ROOT_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [ROW_W-1:0] pack_row(logic [COEFF_W-1:0] c0,
                                                logic [COEFF_W-1:0] c1,
                                                logic [COEFF_W-1:0] c2);
    return {c2, c1, c0};
  endfunction

  function automatic logic [COEFF_W-1:0] rand_coeff(row_kind_t kind, bit on_diag);
    int v;
    case (kind)
      ROW_FULL: begin
        v = $urandom;
      end
      ROW_MODERATE: begin
        // Within +/-2.0, where results mostly stay in range.
        v = $urandom_range(0, 65536);
        v -= 32768;
      end
      ROW_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       v = COEFF_MAX;
          1:       v = COEFF_MIN;
          2:       v = COEFF_NEG_LSB;
          3:       v = COEFF_ONE;
          default: v = COEFF_ZERO;
        endcase
      end
      default: begin
        // Small cross terms, diagonal near 1.0: a typical calibration.
        v = $urandom_range(0, 2048);
        v -= 1024;
        if (on_diag) begin
          v += COEFF_ONE;
        end
      end
    endcase
    return v[COEFF_W-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] rand_row(row_kind_t kind, int diag);
    return pack_row(rand_coeff(kind, diag == 0), rand_coeff(kind, diag == 1),
                    rand_coeff(kind, diag == 2));
  endfunction

  function automatic logic signed [MEAS_W-1:0] rand_meas();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom;
      5, 6, 7: begin
        v = $urandom_range(0, 8191);
        v -= 4096;
      end
      8: begin
        case ($urandom_range(0, 4))
          0:       v = MEAS_MAX;
          1:       v = MEAS_MIN;
          2:       v = -1;
          3:       v = 1;
          default: v = 0;
        endcase
      end
      default: begin
        // Near full scale, either sign.
        v = $urandom_range(8388607 - 4096, 8388607);
        if ($urandom_range(0, 1) == 1) begin
          v = -v;
        end
      end
    endcase
    return v[MEAS_W-1:0];
  endfunction

  task automatic queue_sample(logic signed [MEAS_W-1:0] x,
                              logic signed [MEAS_W-1:0] y,
                              logic signed [MEAS_W-1:0] z);
    sample_t s;
    s.x = x;
    s.y = y;
    s.z = z;
    sample_q.push_back(s);
    n_queued++;
  endtask

  // One register write. Indexes past the last row must leave the matrix alone.
  task automatic write_row(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx < NUM_AXES) begin
      row_cfg[idx[1:0]] = value;
    end
  endtask

  task automatic load_matrix(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                             logic [ROW_W-1:0] r2);
    write_row(CFG_ROW0, r0);
    write_row(CFG_ROW1, r1);
    write_row(CFG_ROW2, r2);
    n_settings++;
  endtask

  // Waits until every queued sample has been taken and its result checked.
  // Every request gives exactly one result, so nothing remains in flight then.
  task automatic drain();
    while (n_accepted != n_queued || pending_corrections.size() != 0) begin
      @(posedge clk);
    end
    repeat (2) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued samples on the input channel. Once valid is raised
  // it holds, payload unchanged, until the block takes the request. Between
  // requests it may insert an idle burst of random length.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    logic    valid_next;
    logic    taken;
    sample_t s;
    int      gap_left;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      taken = in_valid && in_ready;
      if (taken) begin
        s.x = meas_x;
        s.y = meas_y;
        s.z = meas_z;
        pending_corrections.push_back(correct_sample(s));
        n_accepted++;
      end
      if (!in_valid || taken) begin
        valid_next = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_q.size() != 0) begin
          if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            gap_left = $urandom_range(0, 5);
          end else begin
            s = sample_q.pop_front();
            meas_x <= s.x;
            meas_y <= s.y;
            meas_z <= s.z;
            valid_next = 1'b1;
          end
        end
        in_valid <= valid_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver readiness: random stall bursts plus one long hold-off on request.
  // The hold-off is counted here so that the sender keeps pushing while the
  // output is blocked; the pipeline then fills and in_ready must drop without
  // losing or duplicating anything.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_ready
    logic ready_next;
    int   stall_left;
    int   hold_left;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      ready_next = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 5);
        ready_next = 1'b0;
      end
      out_ready <= ready_next;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every accepted result is matched against the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin : check_results
    corr_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_corrections.size() == 0) begin
        $error("result with no request outstanding: corr_x %0d corr_y %0d corr_z %0d",
               corr_x, corr_y, corr_z);
        n_fail++;
      end else begin
        want = pending_corrections.pop_front();
        check_field("corr_x", want.x, corr_x);
        check_field("corr_y", want.y, corr_y);
        check_field("corr_z", want.z, corr_z);
        check_field("magnitude", want.mag, magnitude);
        check_field("saturated", want.sat, saturated);
        n_results++;
        if (want.sat) begin
          n_clipped++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $error("run did not finish within %0d cycles", LIMIT_CYCLES);
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: reset, a directed part, then random phases. Each phase sets a
  // matrix while the block is empty, queues samples and waits for them all.
  // --------------------------------------------------------------------------
  initial begin
    int        p;
    row_kind_t kind;
    row_cfg[0] = ROW0_RESET;
    row_cfg[1] = ROW1_RESET;
    row_cfg[2] = ROW2_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Identity matrix straight out of reset: zero, full scale, mixed signs.
    gap_pct   = 20;
    stall_pct = 20;
    queue_sample('0, '0, '0);
    queue_sample(MEAS_MAX, MEAS_MAX, MEAS_MAX);
    queue_sample(MEAS_MIN, MEAS_MIN, MEAS_MIN);
    queue_sample(MEAS_MAX, MEAS_MIN, '0);
    queue_sample(-24'sd1, 24'sd1, -24'sd1);
    drain();

    // Every coefficient one LSB below zero: a product sum of -1 must floor
    // to -1, while +1 floors to 0.
    load_matrix(pack_row(COEFF_NEG_LSB, COEFF_NEG_LSB, COEFF_NEG_LSB),
                pack_row(COEFF_NEG_LSB, COEFF_NEG_LSB, COEFF_NEG_LSB),
                pack_row(COEFF_NEG_LSB, COEFF_NEG_LSB, COEFF_NEG_LSB));
    queue_sample(24'sd1, '0, '0);
    queue_sample(-24'sd1, '0, '0);
    queue_sample('0, '0, '0);
    drain();

    // Largest positive coefficients: overflow clips high or low.
    load_matrix(pack_row(COEFF_MAX, COEFF_MAX, COEFF_MAX),
                pack_row(COEFF_MAX, COEFF_MAX, COEFF_MAX),
                pack_row(COEFF_MAX, COEFF_MAX, COEFF_MAX));
    queue_sample(MEAS_MAX, MEAS_MAX, MEAS_MAX);
    queue_sample(MEAS_MIN, MEAS_MIN, MEAS_MIN);
    queue_sample(24'sd1, 24'sd1, 24'sd1);
    drain();

    // Most negative coefficients. Full-scale positive inputs clip every component to
    // the negative rail, which gives the largest possible magnitude; negative ones clip high.
    load_matrix(pack_row(COEFF_MIN, COEFF_MIN, COEFF_MIN),
                pack_row(COEFF_MIN, COEFF_MIN, COEFF_MIN),
                pack_row(COEFF_MIN, COEFF_MIN, COEFF_MIN));
    queue_sample(MEAS_MIN, MEAS_MIN, MEAS_MIN);
    queue_sample(MEAS_MAX, MEAS_MAX, MEAS_MAX);
    queue_sample(MEAS_MAX, '0, '0);
    drain();

    // Axis permutation with a sign flip, then a write to an unused index,
    // which must not disturb the matrix.
    load_matrix(pack_row(COEFF_ZERO, COEFF_ONE, COEFF_ZERO),
                pack_row(COEFF_ZERO, COEFF_ZERO, COEFF_ONE),
                pack_row(18'h3C000, COEFF_ZERO, COEFF_ZERO));
    write_row(CFG_IDX_W'(CFG_ROW2 + 1), rand_row(ROW_FULL, 0));
    queue_sample(24'sd123456, -24'sd654321, 24'sd777);
    queue_sample(MEAS_MIN, MEAS_MAX, -24'sd1);
    queue_sample(-24'sd5, 24'sd3, MEAS_MIN);
    drain();

    // Random phases. The last two run with no idling on either side.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      kind = (p == 0) ? ROW_FULL : row_kind_t'($urandom_range(0, 3));
      load_matrix(rand_row(kind, 0), rand_row(kind, 1), rand_row(kind, 2));
      if ($urandom_range(0, 2) == 0) begin
        write_row(CFG_IDX_W'($urandom_range(NUM_AXES, (1 << CFG_IDX_W) - 1)),
                  rand_row(ROW_FULL, 0));
      end
      if (p >= RANDOM_PHASES - 2) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(0, 3) * 15;
        stall_pct = $urandom_range(0, 3) * 15;
      end
      if (p == 1) begin
        // Sender runs flat out into the long receiver hold-off.
        gap_pct  = 0;
        hold_req = 1'b1;
      end
      repeat (PHASE_ITEMS) queue_sample(rand_meas(), rand_meas(), rand_meas());
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d corrected samples across %0d matrix settings.",
             n_results, n_settings);
    $display("%0d results clipped; %0d mismatches.", n_clipped, n_fail);
    if (n_fail == 0 && pending_corrections.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
